// File: hdl/lavm_pkg.sv
// ----------------------------------------------------------------------------
// Look-at view matrix package
// Shared widths, latency figures, flag types and helper functions.
// ----------------------------------------------------------------------------
package lavm_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int FIELD_W       = 18;
  localparam int MAG_W         = 30;
  localparam int ROOT_W        = 31;
  localparam int SQ_W          = 62;

  typedef struct packed {
    logic vld;
    logic zero;
  } flag_t;

  // Normalizer depth: abs, lead search, scale, square, sum, root bits,
  // divider setup, quotient bits, sign.
  function automatic int norm_lat(input int frac);
    return 5 + ROOT_W + 1 + (frac + 1) + 1;
  endfunction

  function automatic logic [FIELD_W-1:0] fit_field(input logic signed [63:0] v);
    return v[FIELD_W-1:0];
  endfunction

endpackage

// File: hdl/lavm_dly.sv
// ----------------------------------------------------------------------------
// Delay line
// Fixed-depth register chain that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module lavm_dly #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic [W-1:0] data_i,
  output logic [W-1:0] data_o
);
  logic [W-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    tap_r[0] <= data_i;
    for (int i = 1; i < DEPTH; i++) begin
      tap_r[i] <= tap_r[i-1];
    end
  end

  assign data_o = tap_r[DEPTH-1];

endmodule

// File: hdl/lavm_norm.sv
// ----------------------------------------------------------------------------
// Vector normalizer
// Scales a signed 3-vector to unit length: magnitude scaling, squared sum,
// one root bit per stage, then one quotient bit per stage for each lane.
// ----------------------------------------------------------------------------
module lavm_norm #(
  parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF,
  parameter int IN_W      = lavm_pkg::COORD_W + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic signed [IN_W-1:0]      vec_i [3],
  output logic signed [FRAC_BITS+1:0] unit_o [3],
  output lavm_pkg::flag_t             flag_o
);
  import lavm_pkg::*;

  localparam int PW        = $clog2(IN_W);
  localparam int UW        = FRAC_BITS + 2;
  localparam int DW        = ROOT_W + FRAC_BITS + 1;
  localparam int QW        = FRAC_BITS + 1;
  localparam int DST       = FRAC_BITS + 1;
  localparam int LAT       = norm_lat(FRAC_BITS);
  localparam int SHIFT_REF = MAG_W - 1;
  localparam int BNDW      = 3 + 1 + 3 * MAG_W;
  localparam int UNIT      = 1 << FRAC_BITS;

  // Stage 1: sign and magnitude.
  logic              st1_vld_r;
  logic [IN_W-1:0]   st1_mag_r [3];
  logic [2:0]        st1_sgn_r;
  // Stage 2: leading one of the largest magnitude.
  logic              st2_vld_r;
  logic [IN_W-1:0]   st2_mag_r [3];
  logic [2:0]        st2_sgn_r;
  logic [PW-1:0]     st2_pos_r;
  logic              st2_zero_r;
  logic [IN_W-1:0]   or_all;
  logic [PW-1:0]     pos_nxt;
  // Stage 3: magnitudes scaled so the largest sits in [2^29, 2^30).
  logic              st3_vld_r;
  logic [MAG_W-1:0]  st3_mag_r [3];
  logic [2:0]        st3_sgn_r;
  logic              st3_zero_r;
  logic [IN_W-1:0]   sh_wide [3];
  logic [MAG_W-1:0]  st3_mag_nxt [3];
  // Stages 4 and 5: squares and their sum.
  logic                 st4_vld_r;
  logic [2*MAG_W-1:0]   st4_sq_r [3];
  logic                 st5_vld_r;
  logic [SQ_W-1:0]      st5_sum_r;
  // Square root, one result bit per stage.
  logic                 sq_vld_r  [ROOT_W];
  logic [SQ_W-1:0]      sq_rem_r  [ROOT_W];
  logic [ROOT_W-1:0]    sq_root_r [ROOT_W];
  // Side data carried past the root stages.
  logic [BNDW-1:0]      bnd_in, bnd_out;
  logic [MAG_W-1:0]     bnd_mag [3];
  logic [2:0]           bnd_sgn;
  logic                 bnd_zero;
  // Divider setup.
  logic                 pr_vld_r;
  logic [DW-1:0]        pr_rem_r [3];
  logic [ROOT_W-1:0]    pr_len_r;
  logic [2:0]           pr_sgn_r;
  logic                 pr_zero_r;
  // Divider, one quotient bit per stage.
  logic                 dv_vld_r  [DST];
  logic [DW-1:0]        dv_rem_r  [DST][3];
  logic [QW-1:0]        dv_q_r    [DST][3];
  logic [ROOT_W-1:0]    dv_len_r  [DST];
  logic [2:0]           dv_sgn_r  [DST];
  logic                 dv_zero_r [DST];
  // Final sign and zero gating.
  logic                 fin_vld_r;
  logic                 fin_zero_r;
  logic signed [UW-1:0] fin_unit_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_vld_r <= 1'b0;
      st2_vld_r <= 1'b0;
      st3_vld_r <= 1'b0;
      st4_vld_r <= 1'b0;
      st5_vld_r <= 1'b0;
      pr_vld_r  <= 1'b0;
      fin_vld_r <= 1'b0;
    end else begin
      st1_vld_r <= in_vld;
      st2_vld_r <= st1_vld_r;
      st3_vld_r <= st2_vld_r;
      st4_vld_r <= st3_vld_r;
      st5_vld_r <= st4_vld_r;
      pr_vld_r  <= sq_vld_r[ROOT_W-1];
      fin_vld_r <= dv_vld_r[DST-1];
    end
  end

  always_comb begin
    or_all  = st1_mag_r[0] | st1_mag_r[1] | st1_mag_r[2];
    pos_nxt = '0;
    for (int b = 0; b < IN_W; b++) begin
      if (or_all[b]) pos_nxt = PW'(b);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (st2_pos_r >= PW'(SHIFT_REF)) begin
        sh_wide[i] = st2_mag_r[i] >> (st2_pos_r - PW'(SHIFT_REF));
      end else begin
        sh_wide[i] = st2_mag_r[i] << (PW'(SHIFT_REF) - st2_pos_r);
      end
      st3_mag_nxt[i] = sh_wide[i][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      st1_sgn_r[i] <= vec_i[i][IN_W-1];
      st1_mag_r[i] <= vec_i[i][IN_W-1] ? IN_W'(-vec_i[i]) : IN_W'(vec_i[i]);
      st2_mag_r[i] <= st1_mag_r[i];
      st3_mag_r[i] <= st3_mag_nxt[i];
      st4_sq_r[i]  <= (2*MAG_W)'(st3_mag_r[i]) * (2*MAG_W)'(st3_mag_r[i]);
    end
    st2_sgn_r  <= st1_sgn_r;
    st2_pos_r  <= pos_nxt;
    st2_zero_r <= (or_all == '0);
    st3_sgn_r  <= st2_sgn_r;
    st3_zero_r <= st2_zero_r;
    st5_sum_r  <= SQ_W'(st4_sq_r[0]) + SQ_W'(st4_sq_r[1]) + SQ_W'(st4_sq_r[2]);
  end

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    localparam int B = ROOT_W - 1 - j;
    logic [SQ_W-1:0]   rem_in;
    logic [SQ_W-1:0]   trial;
    logic [ROOT_W-1:0] root_in;
    logic              vld_in;
    if (j == 0) begin : g_first
      assign rem_in  = st5_sum_r;
      assign root_in = '0;
      assign vld_in  = st5_vld_r;
    end else begin : g_next
      assign rem_in  = sq_rem_r[j-1];
      assign root_in = sq_root_r[j-1];
      assign vld_in  = sq_vld_r[j-1];
    end
    assign trial = (SQ_W'(root_in) << (B + 1)) | (SQ_W'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (rem_in >= trial) begin
        sq_rem_r[j]  <= rem_in - trial;
        sq_root_r[j] <= root_in | (ROOT_W'(1) << B);
      end else begin
        sq_rem_r[j]  <= rem_in;
        sq_root_r[j] <= root_in;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[j] <= 1'b0;
      end else begin
        sq_vld_r[j] <= vld_in;
      end
    end
  end

  assign bnd_in = {st3_sgn_r, st3_zero_r, st3_mag_r[2], st3_mag_r[1], st3_mag_r[0]};

  lavm_dly #(
    .W     (BNDW),
    .DEPTH (ROOT_W + 2)
  ) u_bnd_dly (
    .clk    (clk),
    .data_i (bnd_in),
    .data_o (bnd_out)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bnd_mag[i] = bnd_out[i*MAG_W +: MAG_W];
    end
    bnd_zero = bnd_out[3*MAG_W];
    bnd_sgn  = bnd_out[3*MAG_W+1 +: 3];
  end

  // Half the length is added up front so the quotient comes out rounded.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pr_rem_r[i] <= (DW'(bnd_mag[i]) << FRAC_BITS) + DW'(sq_root_r[ROOT_W-1] >> 1);
    end
    pr_len_r  <= sq_root_r[ROOT_W-1];
    pr_sgn_r  <= bnd_sgn;
    pr_zero_r <= bnd_zero;
  end

  for (genvar k = 0; k < DST; k++) begin : g_div
    localparam int B = FRAC_BITS - k;
    logic [DW-1:0]     rem_in [3];
    logic [QW-1:0]     q_in   [3];
    logic [ROOT_W-1:0] len_in;
    logic [2:0]        sgn_in;
    logic              zero_in;
    logic              vld_in;
    logic [DW-1:0]     cmp;
    if (k == 0) begin : g_first
      assign rem_in  = pr_rem_r;
      assign q_in    = '{default: '0};
      assign len_in  = pr_len_r;
      assign sgn_in  = pr_sgn_r;
      assign zero_in = pr_zero_r;
      assign vld_in  = pr_vld_r;
    end else begin : g_next
      assign rem_in  = dv_rem_r[k-1];
      assign q_in    = dv_q_r[k-1];
      assign len_in  = dv_len_r[k-1];
      assign sgn_in  = dv_sgn_r[k-1];
      assign zero_in = dv_zero_r[k-1];
      assign vld_in  = dv_vld_r[k-1];
    end
    assign cmp = DW'(len_in) << B;
    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        if (rem_in[i] >= cmp) begin
          dv_rem_r[k][i] <= rem_in[i] - cmp;
          dv_q_r[k][i]   <= q_in[i] | (QW'(1) << B);
        end else begin
          dv_rem_r[k][i] <= rem_in[i];
          dv_q_r[k][i]   <= q_in[i];
        end
      end
      dv_len_r[k]  <= len_in;
      dv_sgn_r[k]  <= sgn_in;
      dv_zero_r[k] <= zero_in;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k] <= 1'b0;
      end else begin
        dv_vld_r[k] <= vld_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (dv_zero_r[DST-1]) begin
        fin_unit_r[i] <= '0;
      end else if (dv_sgn_r[DST-1][i]) begin
        fin_unit_r[i] <= -UW'(dv_q_r[DST-1][i]);
      end else begin
        fin_unit_r[i] <= UW'(dv_q_r[DST-1][i]);
      end
    end
    fin_zero_r <= dv_zero_r[DST-1];
  end

  assign unit_o      = fin_unit_r;
  assign flag_o.vld  = fin_vld_r;
  assign flag_o.zero = fin_zero_r;

  a_norm_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld |-> ##LAT flag_o.vld)
    else $error("normalizer beat lost or misaligned");

  a_norm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    flag_o.vld && flag_o.zero |-> unit_o[0] == '0 && unit_o[1] == '0 && unit_o[2] == '0)
    else $error("zero-length vector gave a nonzero unit vector");

  a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    flag_o.vld |-> unit_o[0] <= UNIT && unit_o[0] >= -UNIT &&
                   unit_o[1] <= UNIT && unit_o[1] >= -UNIT &&
                   unit_o[2] <= UNIT && unit_o[2] >= -UNIT)
    else $error("unit vector component exceeds one");

endmodule

// File: hdl/lavm_xprod.sv
// ----------------------------------------------------------------------------
// Cross product
// Exact signed cross product: six registered products, then the differences.
// ----------------------------------------------------------------------------
module lavm_xprod #(
  parameter int A_W = 32,
  parameter int B_W = 18
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  logic signed [A_W-1:0]    a_i [3],
  input  logic signed [B_W-1:0]    b_i [3],
  output logic signed [A_W+B_W:0]  c_o [3],
  output logic                     out_vld
);
  localparam int PW = A_W + B_W;
  localparam int CW = A_W + B_W + 1;

  logic                 p_vld_r;
  logic signed [PW-1:0] p_r [6];
  logic                 c_vld_r;
  logic signed [CW-1:0] c_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      p_vld_r <= in_vld;
      c_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p_r[0] <= PW'(a_i[1]) * PW'(b_i[2]);
    p_r[1] <= PW'(a_i[2]) * PW'(b_i[1]);
    p_r[2] <= PW'(a_i[2]) * PW'(b_i[0]);
    p_r[3] <= PW'(a_i[0]) * PW'(b_i[2]);
    p_r[4] <= PW'(a_i[0]) * PW'(b_i[1]);
    p_r[5] <= PW'(a_i[1]) * PW'(b_i[0]);
    for (int i = 0; i < 3; i++) begin
      c_r[i] <= CW'(p_r[2*i]) - CW'(p_r[2*i+1]);
    end
  end

  assign c_o     = c_r;
  assign out_vld = c_vld_r;

endmodule

// File: hdl/lavm_shift.sv
// ----------------------------------------------------------------------------
// Translation column
// Minus each rotation row dotted with the eye, rounded and saturated.
// ----------------------------------------------------------------------------
module lavm_shift #(
  parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_vld,
  input  logic signed [FRAC_BITS+1:0]           row_i [3][3],
  input  logic signed [lavm_pkg::COORD_W-1:0]   eye_i [3],
  output logic signed [lavm_pkg::COORD_W-1:0]   shift_o [3],
  output logic                                  out_vld
);
  import lavm_pkg::*;

  localparam int PW = COORD_W + FRAC_BITS + 2;
  localparam int SW = PW + 2;
  localparam logic [SW-1:0] HALF    = SW'(1) << (FRAC_BITS - 1);
  localparam logic [SW-1:0] POS_LIM = SW'(64'h7FFF_FFFF);
  localparam logic [SW-1:0] NEG_LIM = SW'(64'h8000_0000);
  localparam logic [COORD_W-1:0] MAX_V = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] MIN_V = {1'b1, {(COORD_W-1){1'b0}}};

  logic                 p_vld_r, d_vld_r, t_vld_r;
  logic signed [PW-1:0] p_r [3][3];
  logic signed [SW-1:0] d_r [3];
  logic [SW-1:0]        mag [3];
  logic [SW-1:0]        rnd [3];
  logic                 neg [3];
  logic [COORD_W-1:0]   t_nxt [3];
  logic [COORD_W-1:0]   t_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      t_vld_r <= 1'b0;
    end else begin
      p_vld_r <= in_vld;
      d_vld_r <= p_vld_r;
      t_vld_r <= d_vld_r;
    end
  end

  // The term is negated, so a positive dot product gives a negative result.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      neg[r] = (d_r[r] > 0);
      mag[r] = d_r[r][SW-1] ? SW'(-d_r[r]) : SW'(d_r[r]);
      rnd[r] = (mag[r] + HALF) >> FRAC_BITS;
      if (neg[r]) begin
        t_nxt[r] = (rnd[r] > NEG_LIM) ? MIN_V : -COORD_W'(rnd[r]);
      end else begin
        t_nxt[r] = (rnd[r] > POS_LIM) ? MAX_V : COORD_W'(rnd[r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p_r[r][c] <= PW'(row_i[r][c]) * PW'(eye_i[c]);
      end
      d_r[r] <= SW'(p_r[r][0]) + SW'(p_r[r][1]) + SW'(p_r[r][2]);
      t_r[r] <= t_nxt[r];
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      shift_o[r] = t_r[r];
    end
  end
  assign out_vld = t_vld_r;

endmodule

// File: hdl/look_at_view_matrix_unit.sv
// ----------------------------------------------------------------------------
// Look-at view matrix unit
// Builds the top three rows of a right-handed view matrix from eye, target
// and up hint. One item is taken on every clock cycle and busy is never
// raised. Each result appears on the out_ ports for a single cycle, marked
// by out_valid; the receiver cannot stall it. Most of the pipeline lies in
// the two normalizers, each a chain of one square-root stage per root bit
// and one divider stage per quotient bit. A zero-length direction or right
// vector gives an all-zero result.
// ----------------------------------------------------------------------------
module look_at_view_matrix_unit #(
  parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [lavm_pkg::COORD_W-1:0] in_eye_x,
  input  logic signed [lavm_pkg::COORD_W-1:0] in_eye_y,
  input  logic signed [lavm_pkg::COORD_W-1:0] in_eye_z,
  input  logic signed [lavm_pkg::COORD_W-1:0] in_target_x,
  input  logic signed [lavm_pkg::COORD_W-1:0] in_target_y,
  input  logic signed [lavm_pkg::COORD_W-1:0] in_target_z,
  input  logic signed [lavm_pkg::COORD_W-1:0] in_up_x,
  input  logic signed [lavm_pkg::COORD_W-1:0] in_up_y,
  input  logic signed [lavm_pkg::COORD_W-1:0] in_up_z,
  output logic                                out_valid,
  output logic signed [lavm_pkg::FIELD_W-1:0] out_right_x,
  output logic signed [lavm_pkg::FIELD_W-1:0] out_right_y,
  output logic signed [lavm_pkg::FIELD_W-1:0] out_right_z,
  output logic signed [lavm_pkg::COORD_W-1:0] out_right_shift,
  output logic signed [lavm_pkg::FIELD_W-1:0] out_true_up_x,
  output logic signed [lavm_pkg::FIELD_W-1:0] out_true_up_y,
  output logic signed [lavm_pkg::FIELD_W-1:0] out_true_up_z,
  output logic signed [lavm_pkg::COORD_W-1:0] out_up_shift,
  output logic signed [lavm_pkg::FIELD_W-1:0] out_dir_x,
  output logic signed [lavm_pkg::FIELD_W-1:0] out_dir_y,
  output logic signed [lavm_pkg::FIELD_W-1:0] out_dir_z,
  output logic signed [lavm_pkg::COORD_W-1:0] out_dir_shift
);
  import lavm_pkg::*;

  localparam int UW   = FRAC_BITS + 2;
  localparam int NL   = norm_lat(FRAC_BITS);
  localparam int LAT  = 10 + 2 * NL;
  localparam int CW   = COORD_W + UW + 1;
  localparam int XW   = 2 * UW + 1;
  localparam logic [XW-1:0] TU_HALF = XW'(1) << (FRAC_BITS - 1);
  localparam logic [XW-1:0] TU_UNIT = XW'(1) << FRAC_BITS;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Difference stage.
  logic                    va_r;
  logic signed [COORD_W:0] d_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    d_r[0] <= (COORD_W+1)'(in_eye_x) - (COORD_W+1)'(in_target_x);
    d_r[1] <= (COORD_W+1)'(in_eye_y) - (COORD_W+1)'(in_target_y);
    d_r[2] <= (COORD_W+1)'(in_eye_z) - (COORD_W+1)'(in_target_z);
  end

  // Eye and up hint wait beside the pipeline.
  logic [3*COORD_W-1:0]        eye_flat, up_flat;
  logic signed [COORD_W-1:0]   eye_e [3];
  logic signed [COORD_W-1:0]   up_e  [3];

  lavm_dly #(.W(3*COORD_W), .DEPTH(6 + 2*NL)) u_eye_dly (
    .clk    (clk),
    .data_i ({in_eye_z, in_eye_y, in_eye_x}),
    .data_o (eye_flat)
  );

  lavm_dly #(.W(3*COORD_W), .DEPTH(1 + NL)) u_up_dly (
    .clk    (clk),
    .data_i ({in_up_z, in_up_y, in_up_x}),
    .data_o (up_flat)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eye_e[i] = eye_flat[i*COORD_W +: COORD_W];
      up_e[i]  = up_flat[i*COORD_W +: COORD_W];
    end
  end

  // Direction.
  logic signed [UW-1:0] dir1 [3];
  flag_t                flag1;

  lavm_norm #(.FRAC_BITS(FRAC_BITS), .IN_W(COORD_W + 1)) u_norm_dir (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (va_r),
    .vec_i  (d_r),
    .unit_o (dir1),
    .flag_o (flag1)
  );

  // Right = up x dir.
  logic signed [CW-1:0] c1 [3];
  logic                 x1_vld;

  lavm_xprod #(.A_W(COORD_W), .B_W(UW)) u_xprod_right (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (flag1.vld),
    .a_i     (up_e),
    .b_i     (dir1),
    .c_o     (c1),
    .out_vld (x1_vld)
  );

  logic signed [UW-1:0] right2 [3];
  flag_t                flag2;

  lavm_norm #(.FRAC_BITS(FRAC_BITS), .IN_W(CW)) u_norm_right (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (x1_vld),
    .vec_i  (c1),
    .unit_o (right2),
    .flag_o (flag2)
  );

  // Unit vectors are carried as packed words through the delay lines.
  logic [3*UW-1:0]      dir1_flat, right2_flat, tu_flat;
  logic [3*UW-1:0]      dir_d_flat, dir_e_flat, dir_f_flat;
  logic [3*UW-1:0]      right_e_flat, right_f_flat, tu_f_flat;
  logic signed [UW-1:0] dir_d [3], dir_e [3], dir_f [3];
  logic signed [UW-1:0] right_e [3], right_f [3], tu_f [3];
  logic [0:0]           zero_f;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir1_flat[i*UW +: UW]   = dir1[i];
      right2_flat[i*UW +: UW] = right2[i];
    end
  end

  lavm_dly #(.W(3*UW), .DEPTH(2 + NL)) u_dir_dly_d (
    .clk (clk), .data_i (dir1_flat), .data_o (dir_d_flat)
  );
  lavm_dly #(.W(3*UW), .DEPTH(3)) u_dir_dly_e (
    .clk (clk), .data_i (dir_d_flat), .data_o (dir_e_flat)
  );
  lavm_dly #(.W(3*UW), .DEPTH(3)) u_dir_dly_f (
    .clk (clk), .data_i (dir_e_flat), .data_o (dir_f_flat)
  );
  lavm_dly #(.W(3*UW), .DEPTH(3)) u_right_dly_e (
    .clk (clk), .data_i (right2_flat), .data_o (right_e_flat)
  );
  lavm_dly #(.W(3*UW), .DEPTH(3)) u_right_dly_f (
    .clk (clk), .data_i (right_e_flat), .data_o (right_f_flat)
  );
  lavm_dly #(.W(3*UW), .DEPTH(3)) u_tu_dly_f (
    .clk (clk), .data_i (tu_flat), .data_o (tu_f_flat)
  );
  lavm_dly #(.W(1), .DEPTH(6)) u_zero_dly (
    .clk (clk), .data_i (flag2.zero), .data_o (zero_f)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir_d[i]   = dir_d_flat[i*UW +: UW];
      dir_e[i]   = dir_e_flat[i*UW +: UW];
      dir_f[i]   = dir_f_flat[i*UW +: UW];
      right_e[i] = right_e_flat[i*UW +: UW];
      right_f[i] = right_f_flat[i*UW +: UW];
      tu_f[i]    = tu_f_flat[i*UW +: UW];
    end
  end

  // True up = dir x right, rounded back to the unit scale and clamped.
  logic signed [XW-1:0] x2 [3];
  logic                 x2_vld;

  lavm_xprod #(.A_W(UW), .B_W(UW)) u_xprod_up (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (flag2.vld),
    .a_i     (dir_d),
    .b_i     (right2),
    .c_o     (x2),
    .out_vld (x2_vld)
  );

  logic                 tu_vld_r;
  logic signed [UW-1:0] tu_r   [3];
  logic signed [UW-1:0] tu_nxt [3];
  logic [XW-1:0]        tu_mag [3];
  logic [XW-1:0]        tu_rnd [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tu_mag[i] = x2[i][XW-1] ? XW'(-x2[i]) : XW'(x2[i]);
      tu_rnd[i] = (tu_mag[i] + TU_HALF) >> FRAC_BITS;
      if (tu_rnd[i] > TU_UNIT) begin
        tu_rnd[i] = TU_UNIT;
      end
      tu_nxt[i] = x2[i][XW-1] ? -UW'(tu_rnd[i]) : UW'(tu_rnd[i]);
      tu_flat[i*UW +: UW] = tu_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tu_vld_r <= 1'b0;
    end else begin
      tu_vld_r <= x2_vld;
    end
  end

  always_ff @(posedge clk) begin
    tu_r <= tu_nxt;
  end

  // Translation column.
  logic signed [UW-1:0]      rows [3][3];
  logic signed [COORD_W-1:0] sh   [3];
  logic                      sh_vld;

  assign rows[0] = right_e;
  assign rows[1] = tu_r;
  assign rows[2] = dir_e;

  lavm_shift #(.FRAC_BITS(FRAC_BITS)) u_shift (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (tu_vld_r),
    .row_i   (rows),
    .eye_i   (eye_e),
    .shift_o (sh),
    .out_vld (sh_vld)
  );

  // Output register.
  logic                      out_valid_r;
  logic [FIELD_W-1:0]        right_o_r [3];
  logic [FIELD_W-1:0]        tu_o_r    [3];
  logic [FIELD_W-1:0]        dir_o_r   [3];
  logic [COORD_W-1:0]        sh_o_r    [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sh_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (zero_f[0]) begin
        right_o_r[i] <= '0;
        tu_o_r[i]    <= '0;
        dir_o_r[i]   <= '0;
        sh_o_r[i]    <= '0;
      end else begin
        right_o_r[i] <= fit_field(64'(right_f[i]));
        tu_o_r[i]    <= fit_field(64'(tu_f[i]));
        dir_o_r[i]   <= fit_field(64'(dir_f[i]));
        sh_o_r[i]    <= sh[i];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_right_x     = right_o_r[0];
  assign out_right_y     = right_o_r[1];
  assign out_right_z     = right_o_r[2];
  assign out_right_shift = sh_o_r[0];
  assign out_true_up_x   = tu_o_r[0];
  assign out_true_up_y   = tu_o_r[1];
  assign out_true_up_z   = tu_o_r[2];
  assign out_up_shift    = sh_o_r[1];
  assign out_dir_x       = dir_o_r[0];
  assign out_dir_y       = dir_o_r[1];
  assign out_dir_z       = dir_o_r[2];
  assign out_dir_shift   = sh_o_r[2];

  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("accepted beat did not produce a result");

  a_lat_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result strobe without a matching start beat");

  a_rst_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result strobe right after reset");

endmodule

// File: test/lavm_checker.sv
// ----------------------------------------------------------------------------
// Look-at view matrix checker
// Watches the start and result channels of the view matrix unit. For every
// accepted start beat it computes the expected matrix rows in fixed point
// and queues them; every result beat is compared field by field with the
// oldest queued matrix.
// ----------------------------------------------------------------------------
module lavm_checker #(
  parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic signed [lavm_pkg::COORD_W-1:0] in_eye_x,
  input  logic signed [lavm_pkg::COORD_W-1:0] in_eye_y,
  input  logic signed [lavm_pkg::COORD_W-1:0] in_eye_z,
  input  logic signed [lavm_pkg::COORD_W-1:0] in_target_x,
  input  logic signed [lavm_pkg::COORD_W-1:0] in_target_y,
  input  logic signed [lavm_pkg::COORD_W-1:0] in_target_z,
  input  logic signed [lavm_pkg::COORD_W-1:0] in_up_x,
  input  logic signed [lavm_pkg::COORD_W-1:0] in_up_y,
  input  logic signed [lavm_pkg::COORD_W-1:0] in_up_z,
  input  logic                                out_valid,
  input  logic signed [lavm_pkg::FIELD_W-1:0] out_right_x,
  input  logic signed [lavm_pkg::FIELD_W-1:0] out_right_y,
  input  logic signed [lavm_pkg::FIELD_W-1:0] out_right_z,
  input  logic signed [lavm_pkg::COORD_W-1:0] out_right_shift,
  input  logic signed [lavm_pkg::FIELD_W-1:0] out_true_up_x,
  input  logic signed [lavm_pkg::FIELD_W-1:0] out_true_up_y,
  input  logic signed [lavm_pkg::FIELD_W-1:0] out_true_up_z,
  input  logic signed [lavm_pkg::COORD_W-1:0] out_up_shift,
  input  logic signed [lavm_pkg::FIELD_W-1:0] out_dir_x,
  input  logic signed [lavm_pkg::FIELD_W-1:0] out_dir_y,
  input  logic signed [lavm_pkg::FIELD_W-1:0] out_dir_z,
  input  logic signed [lavm_pkg::COORD_W-1:0] out_dir_shift,
  output int                                  fail_count,
  output int                                  pending_count
);
  import lavm_pkg::*;

  typedef logic [12*32-1:0] matrix_t;  // 12 fields, 32-bit slot each

  matrix_t view_rows_q[$];

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] s);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Returns 0 for a zero vector.
  function automatic bit unit_vec(input logic signed [63:0] v[3],
                                  output logic signed [63:0] u[3]);
    logic [63:0] m[3];
    logic [63:0] mx, s, len, q;
    mx = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = abs64(v[i]);
      if (m[i] > mx) mx = m[i];
      u[i] = 0;
    end
    if (mx == 0) return 0;
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    for (int i = 0; i < 3; i++) s = s + m[i] * m[i];
    len = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
      u[i] = v[i] < 0 ? -$signed(q) : $signed(q);
    end
    return 1;
  endfunction

  function automatic logic signed [63:0] round_frac(input logic signed [63:0] x);
    logic [63:0] m;
    m = (abs64(x) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return x < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [31:0] translation(input logic signed [63:0] r[3],
                                              input logic signed [63:0] e[3]);
    logic signed [63:0] t;
    t = round_frac(-(r[0] * e[0] + r[1] * e[1] + r[2] * e[2]));
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return t[31:0];
  endfunction

  function automatic matrix_t view_rows(input logic signed [31:0] e32[3],
                                        input logic signed [31:0] t32[3],
                                        input logic signed [31:0] u32[3]);
    logic signed [63:0] eye[3], up[3], d[3], dir[3], c[3], rgt[3], tu[3];
    logic signed [63:0] unit;
    matrix_t r;
    r = '0;
    unit = 64'sd1 <<< FRAC_BITS;
    for (int i = 0; i < 3; i++) begin
      eye[i] = e32[i];
      up[i] = u32[i];
      d[i] = eye[i] - 64'(t32[i]);
    end
    if (!unit_vec(d, dir)) return r;
    c[0] = up[1] * dir[2] - up[2] * dir[1];
    c[1] = up[2] * dir[0] - up[0] * dir[2];
    c[2] = up[0] * dir[1] - up[1] * dir[0];
    if (!unit_vec(c, rgt)) return r;
    tu[0] = round_frac(dir[1] * rgt[2] - dir[2] * rgt[1]);
    tu[1] = round_frac(dir[2] * rgt[0] - dir[0] * rgt[2]);
    tu[2] = round_frac(dir[0] * rgt[1] - dir[1] * rgt[0]);
    for (int i = 0; i < 3; i++) begin
      if (tu[i] > unit) tu[i] = unit;
      if (tu[i] < -unit) tu[i] = -unit;
      r[i*32 +: 32] = {14'b0, rgt[i][FIELD_W-1:0]};
      r[(4+i)*32 +: 32] = {14'b0, tu[i][FIELD_W-1:0]};
      r[(8+i)*32 +: 32] = {14'b0, dir[i][FIELD_W-1:0]};
    end
    r[3*32 +: 32] = translation(rgt, eye);
    r[7*32 +: 32] = translation(tu, eye);
    r[11*32 +: 32] = translation(dir, eye);
    return r;
  endfunction

  assign pending_count = view_rows_q.size();

  always @(posedge clk) begin
    matrix_t got, want;
    int errs;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      errs = 0;
      if (start && !busy)
        view_rows_q.push_back(view_rows('{in_eye_x, in_eye_y, in_eye_z},
                                         '{in_target_x, in_target_y, in_target_z},
                                         '{in_up_x, in_up_y, in_up_z}));
      if (out_valid) begin
        got = {out_dir_shift, 14'b0, out_dir_z, 14'b0, out_dir_y, 14'b0, out_dir_x,
               out_up_shift, 14'b0, out_true_up_z, 14'b0, out_true_up_y,
               14'b0, out_true_up_x,
               out_right_shift, 14'b0, out_right_z, 14'b0, out_right_y,
               14'b0, out_right_x};
        if (view_rows_q.size() == 0) begin
          $display("%0t: result beat with no matrix expected", $time);
          errs = errs + 1;
        end else begin
          want = view_rows_q.pop_front();
          for (int f = 0; f < 12; f++)
            if (got[f*32 +: 32] !== want[f*32 +: 32]) begin
              $display("%0t: field %0d expected %h actual %h", $time, f,
                       want[f*32 +: 32], got[f*32 +: 32]);
              errs = errs + 1;
            end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

// File: test/tb_look_at_view_matrix_unit.sv
// ----------------------------------------------------------------------------
// Look-at view matrix unit testbench
// Drives directed corner cases and random camera setups into the unit in
// random bursts; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_look_at_view_matrix_unit;
  import lavm_pkg::*;

  localparam int LATENCY = 2 * FRAC_BITS_DEF + 88;
  localparam int IDLE_LIMIT = 4 * LATENCY + 2000;

  logic clk, rst_n, start, busy, out_valid;
  logic signed [COORD_W-1:0] in_eye_x, in_eye_y, in_eye_z;
  logic signed [COORD_W-1:0] in_target_x, in_target_y, in_target_z;
  logic signed [COORD_W-1:0] in_up_x, in_up_y, in_up_z;
  logic signed [FIELD_W-1:0] out_right_x, out_right_y, out_right_z;
  logic signed [FIELD_W-1:0] out_true_up_x, out_true_up_y, out_true_up_z;
  logic signed [FIELD_W-1:0] out_dir_x, out_dir_y, out_dir_z;
  logic signed [COORD_W-1:0] out_right_shift, out_up_shift, out_dir_shift;
  int fail_count, pending_count, idle_cycles;

  look_at_view_matrix_unit u_top (.*);
  lavm_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Counts cycles with no beat on either channel; fails the run at IDLE_LIMIT.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_look_at_view_matrix_unit NOT OK");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 131072)) - 65536);
      2: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                     : 32'h80000000 + $urandom_range(0, 3);
      3: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< $urandom_range(0, 20);
      default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  // Holds the beat until it is taken.
  task automatic send_view(input logic [31:0] e[3], input logic [31:0] t[3],
                           input logic [31:0] u[3]);
    start <= 1'b1;
    {in_eye_x, in_eye_y, in_eye_z} <= {e[0], e[1], e[2]};
    {in_target_x, in_target_y, in_target_z} <= {t[0], t[1], t[2]};
    {in_up_x, in_up_y, in_up_z} <= {u[0], u[1], u[2]};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_random(input int kind);
    logic [31:0] e[3], t[3], u[3];
    for (int i = 0; i < 3; i++) begin
      e[i] = rand_coord();
      t[i] = rand_coord();
      u[i] = rand_coord();
    end
    if (kind == 0) t = e;                      // eye on the target
    if (kind == 1) for (int i = 0; i < 3; i++) // up parallel to direction
      u[i] = e[i] - t[i];
    if (kind == 2) u = '{0, 0, 0};
    send_view(e, t, u);
  endtask

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MAXC = 32'h7fff_ffff;
  localparam logic [31:0] MINC = 32'h8000_0000;

  initial begin
    int burst;
    rst_n = 0;
    start = 0;
    {in_eye_x, in_eye_y, in_eye_z, in_target_x, in_target_y, in_target_z} = '0;
    {in_up_x, in_up_y, in_up_z} = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    // Directed: ordinary camera, zero lengths, axis cases, extreme coordinates.
    send_view('{0, 0, 5*ONE}, '{0, 0, 0}, '{0, ONE, 0});
    send_view('{ONE, 2*ONE, 3*ONE}, '{ONE, 2*ONE, 3*ONE}, '{0, ONE, 0});
    send_view('{0, 0, ONE}, '{0, 0, 0}, '{0, 0, ONE});
    send_view('{0, 0, ONE}, '{0, 0, 0}, '{0, 0, 0});
    send_view('{MAXC, MAXC, MAXC}, '{MINC, MINC, MINC}, '{MAXC, MINC, MAXC});
    send_view('{MINC, MINC, MINC}, '{MAXC, MAXC, MAXC}, '{MINC, MAXC, 0});
    send_view('{MAXC, MINC, MAXC}, '{MINC, MAXC, MINC}, '{0, MINC, MAXC});
    send_view('{MAXC, 0, 0}, '{MAXC - 1, 0, 0}, '{0, MAXC, 0});
    send_view('{1, 0, 0}, '{0, 0, 0}, '{0, 1, 1});
    send_view('{MINC, MAXC, 0}, '{0, 0, MINC}, '{1, MINC, MINC});
    send_view('{32'hffffffff, 1, 32'hffffffff}, '{MAXC, MAXC, 0}, '{MAXC, 1, 1});
    send_view('{3*ONE, 0, 4*ONE}, '{0, 0, 0}, '{0, 32'hfff0_0000, 0});
    send_view('{0, 0, 0}, '{0, 7*ONE, 0}, '{ONE, 0, 0});
    for (int i = 0; i < 6; i++) send_random(i % 3);
    start <= 1'b0;
    // Drain fully once before the random part.
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    for (int n = 0; n < 400; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++, n++)
        send_random($urandom_range(0, 19));
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 150)) @(posedge clk);
      end
    end
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("tb_look_at_view_matrix_unit OK");
    else
      $display("tb_look_at_view_matrix_unit NOT OK");
    $finish;
  end

endmodule
